// ===== src/tftpf_pkg.sv =====
// shared types, codes and palette for the tft window and palette pixel feeder
`default_nettype none
package tftpf_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W = 4;

  localparam logic [1:0] REQ_WINDOW = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_PAIR   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic REG_COLUMN_OFFSET = 1'b0;
  localparam logic REG_ROW_OFFSET    = 1'b1;

  localparam logic [7:0] COLUMN_OFFSET_RESET = 8'd2;
  localparam logic [7:0] ROW_OFFSET_RESET    = 8'd1;

  localparam logic [7:0] CMD_COLUMN_RANGE = 8'h2A;
  localparam logic [7:0] CMD_ROW_RANGE    = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic [STEP_W-1:0] STEP_WINDOW_LAST = 4'd10;

  typedef enum logic [1:0] {
    KIND_WINDOW,
    KIND_PIXEL,
    KIND_PAIR
  } kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic [7:0] win_width;
    logic [7:0] win_height;
    logic [3:0] pixel_index;
    logic [7:0] packed_pair;
  } req_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       last;
  } rsp_t;

  // window: col start, col end, row start, row end; pixels: colour bytes in order
  typedef struct packed {
    kind_t       kind;
    logic [31:0] bytes;
  } desc_t;

  function automatic logic [15:0] palette(input logic [3:0] idx);
    logic [15:0] c;
    unique case (idx)
      4'h0: c = 16'h0000;
      4'h1: c = 16'h5143;
      4'h2: c = 16'h512f;
      4'h3: c = 16'h5420;
      4'h4: c = 16'h3295;
      4'h5: c = 16'h4aab;
      4'h6: c = 16'hc618;
      4'h7: c = 16'hef9f;
      4'h8: c = 16'h481f;
      4'h9: c = 16'h051f;
      4'ha: c = 16'h277f;
      4'hb: c = 16'h3720;
      4'hc: c = 16'hfd65;
      4'hd: c = 16'h9bb0;
      4'he: c = 16'habbf;
      default: c = 16'hae7f;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/tftpf_front.sv =====
// front end: offset registers, request decode, window math and palette lookup
`default_nettype none
module tftpf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tftpf_pkg::req_t in_data,
  input  wire logic            queue_full,
  output logic                 push,
  output tftpf_pkg::desc_t     push_desc
);

  logic [7:0] column_offset;
  logic [7:0] row_offset;
  logic [7:0] col_start;
  logic [7:0] col_end;
  logic [7:0] row_start;
  logic [7:0] row_end;
  logic       accept;
  logic       keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= tftpf_pkg::COLUMN_OFFSET_RESET;
      row_offset    <= tftpf_pkg::ROW_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tftpf_pkg::REG_COLUMN_OFFSET: column_offset <= cfg_data;
        tftpf_pkg::REG_ROW_OFFSET:    row_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign col_start = {1'b0, in_data.pos_x} + column_offset;
  assign col_end   = col_start + in_data.win_width + 8'hFF;
  assign row_start = {1'b0, in_data.pos_y} + row_offset;
  assign row_end   = row_start + in_data.win_height + 8'hFF;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    keep            = 1'b1;
    push_desc.kind  = tftpf_pkg::KIND_WINDOW;
    push_desc.bytes = {col_start, col_end, row_start, row_end};
    unique case (in_data.req_type)
      tftpf_pkg::REQ_WINDOW: ;
      tftpf_pkg::REQ_PIXEL: begin
        push_desc.kind  = tftpf_pkg::KIND_PIXEL;
        push_desc.bytes = {tftpf_pkg::palette(in_data.pixel_index), 16'h0000};
      end
      tftpf_pkg::REQ_PAIR: begin
        push_desc.kind  = tftpf_pkg::KIND_PAIR;
        push_desc.bytes = {tftpf_pkg::palette(in_data.packed_pair[7:4]),
                           tftpf_pkg::palette(in_data.packed_pair[3:0])};
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

endmodule
`default_nettype wire

// ===== src/tftpf_queue.sv =====
// short descriptor queue between front and back
`default_nettype none
module tftpf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tftpf_pkg::desc_t push_desc,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output tftpf_pkg::desc_t      head
);

  tftpf_pkg::desc_t mem [tftpf_pkg::QUEUE_DEPTH];
  logic [tftpf_pkg::PTR_W-1:0] wr_ptr;
  logic [tftpf_pkg::PTR_W-1:0] rd_ptr;
  logic [tftpf_pkg::CNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign full       = count == tftpf_pkg::CNT_W'(tftpf_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= tftpf_pkg::CNT_W'(tftpf_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule
`default_nettype wire

// ===== src/tftpf_back.sv =====
// back end: byte sequencer with output register
`default_nettype none
module tftpf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire tftpf_pkg::desc_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tftpf_pkg::rsp_t       out_data
);

  logic [tftpf_pkg::STEP_W-1:0] step;
  tftpf_pkg::rsp_t              rsp;
  logic                         load;
  logic                         emit;

  assign load = !out_valid || out_ready;
  assign emit = load && head_valid;
  assign pop  = emit && rsp.last;

  always_comb begin
    rsp.spi_byte = 8'h00;
    rsp.is_data  = 1'b1;
    rsp.last     = 1'b0;
    unique case (head.kind)
      tftpf_pkg::KIND_WINDOW: begin
        case (step) inside
          4'd0: begin
            rsp.spi_byte = tftpf_pkg::CMD_COLUMN_RANGE;
            rsp.is_data  = 1'b0;
          end
          4'd1, 4'd3, 4'd6, 4'd8: rsp.spi_byte = 8'h00;
          4'd2: rsp.spi_byte = head.bytes[31:24];
          4'd4: rsp.spi_byte = head.bytes[23:16];
          4'd5: begin
            rsp.spi_byte = tftpf_pkg::CMD_ROW_RANGE;
            rsp.is_data  = 1'b0;
          end
          4'd7: rsp.spi_byte = head.bytes[15:8];
          4'd9: rsp.spi_byte = head.bytes[7:0];
          default: begin
            rsp.spi_byte = tftpf_pkg::CMD_MEMORY_WRITE;
            rsp.is_data  = 1'b0;
            rsp.last     = 1'b1;
          end
        endcase
      end
      tftpf_pkg::KIND_PIXEL: begin
        rsp.spi_byte = step[0] ? head.bytes[23:16] : head.bytes[31:24];
        rsp.last     = step[0];
      end
      default: begin
        case (step[1:0])
          2'd0: rsp.spi_byte = head.bytes[31:24];
          2'd1: rsp.spi_byte = head.bytes[23:16];
          2'd2: rsp.spi_byte = head.bytes[15:8];
          default: begin
            rsp.spi_byte = head.bytes[7:0];
            rsp.last     = 1'b1;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (emit) begin
        step <= rsp.last ? '0 : step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= rsp;
    end
  end

  assert property (@(posedge clk) disable iff (rst) step <= tftpf_pkg::STEP_WINDOW_LAST)
    else $error("step out of range");
  assert property (@(posedge clk) disable iff (rst) pop |=> step == '0)
    else $error("step not cleared after last byte");
  assert property (@(posedge clk) disable iff (rst) emit |=> (out_valid && out_data == $past(rsp)))
    else $error("output register not loaded");

endmodule
`default_nettype wire

// ===== src/tft_window_and_palette_pixel_feeder_core.sv =====
// top level of the tft window and palette pixel feeder
// Drawing requests enter on in_valid/in_ready with an in_data request struct
// and leave as a stream of display bytes on out_valid/out_ready, one byte per
// item, each tagged with the data/command level and a last mark.
// A set-window request gives 11 bytes, a single pixel 2 bytes, a packed pair
// 4 bytes; request type 3 is taken and gives nothing.
// The back end sends one byte per cycle while the receiver keeps out_ready high
// and the queue holds a request; the bytes of each request go out in order.
// When the queue is empty, the first byte of a taken request is written into a
// queue entry and then into the output register before it shows at the output.
// A four-entry request queue sits between the decode front and the byte
// sequencer; in_ready drops only while that queue is full.
// When the receiver stalls, the output register holds its byte and the queue
// keeps taking requests until it fills.
// Offsets are written on cfg_write/cfg_index/cfg_data: index 0 is the column
// offset, index 1 the row offset; write them only while the block is idle.
// Synchronous reset empties the queue and the output, and sets the column
// offset to 2 and the row offset to 1.
`default_nettype none
module tft_window_and_palette_pixel_feeder_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tftpf_pkg::req_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tftpf_pkg::rsp_t      out_data
);

  logic             push;
  tftpf_pkg::desc_t push_desc;
  logic             full;
  logic             head_valid;
  tftpf_pkg::desc_t head;
  logic             pop;

  tftpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (full),
    .push       (push),
    .push_desc  (push_desc)
  );

  tftpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  tftpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tftpf_byte_checker.sv =====
// checker for the tft pixel feeder: predicts the display bytes and compares them
module tftpf_byte_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tftpf_pkg::req_t   in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tftpf_pkg::rsp_t   out_data,
  output int                errors,
  output int                outstanding
);

  // rgb565 colours, entry 0 in the low bits
  localparam logic [255:0] COLOUR_TABLE = {
    16'hae7f, 16'habbf, 16'h9bb0, 16'hfd65,
    16'h3720, 16'h277f, 16'h051f, 16'h481f,
    16'hef9f, 16'hc618, 16'h4aab, 16'h3295,
    16'h5420, 16'h512f, 16'h5143, 16'h0000
  };

  logic [7:0]      col_offset_q;
  logic [7:0]      row_offset_q;
  tftpf_pkg::rsp_t expected_bytes[$];
  tftpf_pkg::rsp_t oldest;
  int              failures = 0;

  assign errors = failures;

  task automatic push_byte(input logic [7:0] value, input logic data, input logic mark);
    tftpf_pkg::rsp_t b;
    b.spi_byte = value;
    b.is_data  = data;
    b.last     = mark;
    expected_bytes.push_back(b);
  endtask

  task automatic push_range(input logic [7:0] cmd, input logic [7:0] first,
                            input logic [7:0] extent);
    logic [7:0] final_pos;
    final_pos = first + extent - 8'd1;
    push_byte(cmd, 1'b0, 1'b0);
    push_byte(8'd0, 1'b1, 1'b0);
    push_byte(first, 1'b1, 1'b0);
    push_byte(8'd0, 1'b1, 1'b0);
    push_byte(final_pos, 1'b1, 1'b0);
  endtask

  task automatic push_colour(input logic [3:0] idx, input logic mark);
    logic [15:0] colour;
    colour = COLOUR_TABLE[idx*16 +: 16];
    push_byte(colour[15:8], 1'b1, 1'b0);
    push_byte(colour[7:0], 1'b1, mark);
  endtask

  task automatic predict_request(input tftpf_pkg::req_t r);
    logic [7:0] col_start;
    logic [7:0] row_start;
    col_start = {1'b0, r.pos_x} + col_offset_q;
    row_start = {1'b0, r.pos_y} + row_offset_q;
    case (r.req_type)
      tftpf_pkg::REQ_WINDOW: begin
        push_range(tftpf_pkg::CMD_COLUMN_RANGE, col_start, r.win_width);
        push_range(tftpf_pkg::CMD_ROW_RANGE, row_start, r.win_height);
        push_byte(tftpf_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b1);
      end
      tftpf_pkg::REQ_PIXEL: push_colour(r.pixel_index, 1'b1);
      tftpf_pkg::REQ_PAIR: begin
        push_colour(r.packed_pair[7:4], 1'b0);
        push_colour(r.packed_pair[3:0], 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      col_offset_q = tftpf_pkg::COLUMN_OFFSET_RESET;
      row_offset_q = tftpf_pkg::ROW_OFFSET_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == tftpf_pkg::REG_COLUMN_OFFSET) col_offset_q = cfg_data;
        else row_offset_q = cfg_data;
      end
      // output side first: a byte taken now cannot belong to an item taken now
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: spi_byte %h is_data %b last %b",
                 out_data.spi_byte, out_data.is_data, out_data.last);
          failures++;
        end else begin
          oldest = expected_bytes.pop_front();
          if (out_data.spi_byte !== oldest.spi_byte) begin
            $error("spi_byte: expected %h, actual %h", oldest.spi_byte, out_data.spi_byte);
            failures++;
          end
          if (out_data.is_data !== oldest.is_data) begin
            $error("is_data: expected %b, actual %b", oldest.is_data, out_data.is_data);
            failures++;
          end
          if (out_data.last !== oldest.last) begin
            $error("last: expected %b, actual %b", oldest.last, out_data.last);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) predict_request(in_data);
    end
    outstanding <= expected_bytes.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench top for the tft pixel feeder: clock, reset, stimulus and verdict
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  logic            cfg_index = tftpf_pkg::REG_COLUMN_OFFSET;
  logic [7:0]      cfg_data = 8'd0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  tftpf_pkg::req_t in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  tftpf_pkg::rsp_t out_data;
  int              errors;
  int              outstanding;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              quiet_cycles = 0;

  tft_window_and_palette_pixel_feeder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tftpf_byte_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic tftpf_pkg::req_t build_req(input logic [1:0] kind, input logic [6:0] x,
                                                input logic [6:0] y, input logic [7:0] w,
                                                input logic [7:0] h, input logic [3:0] idx,
                                                input logic [7:0] pair);
    tftpf_pkg::req_t r;
    r.req_type    = kind;
    r.pos_x       = x;
    r.pos_y       = y;
    r.win_width   = w;
    r.win_height  = h;
    r.pixel_index = idx;
    r.packed_pair = pair;
    return r;
  endfunction

  function automatic tftpf_pkg::req_t random_req();
    int pick;
    logic [1:0] kind;
    pick = $urandom_range(99);
    if (pick < 30) kind = tftpf_pkg::REQ_WINDOW;
    else if (pick < 60) kind = tftpf_pkg::REQ_PIXEL;
    else if (pick < 90) kind = tftpf_pkg::REQ_PAIR;
    else kind = tftpf_pkg::REQ_UNUSED;
    return build_req(kind, 7'($urandom), 7'($urandom), 8'($urandom), 8'($urandom),
                     4'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_req(input tftpf_pkg::req_t r);
    int gap;
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_bytes(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_offsets(input logic [7:0] col, input logic [7:0] row);
    cfg_write <= 1'b1;
    cfg_index <= tftpf_pkg::REG_COLUMN_OFFSET;
    cfg_data  <= col;
    @(posedge clk);
    cfg_index <= tftpf_pkg::REG_ROW_OFFSET;
    cfg_data  <= row;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // watchdog on cycles with no item taken on either side
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 52, 0, 32};
    stall_by_phase = '{0, 0, 52, 32};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset offsets, field extremes and every request kind
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'd0, 7'd0, 8'd1, 8'd1, 4'hf, 8'hff));
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'd127, 7'd127, 8'd128, 8'd128, 4'h0, 8'h00));
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'($urandom), 7'($urandom), 8'd0, 8'd0,
                       4'($urandom), 8'($urandom)));
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'($urandom), 7'($urandom), 8'hff, 8'hff,
                       4'($urandom), 8'($urandom)));
    send_req(build_req(tftpf_pkg::REQ_PIXEL, 7'h7f, 7'h7f, 8'hff, 8'hff, 4'h0, 8'hff));
    send_req(build_req(tftpf_pkg::REQ_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 4'hf, 8'h00));
    send_req(build_req(tftpf_pkg::REQ_PAIR, 7'($urandom), 7'($urandom), 8'($urandom),
                       8'($urandom), 4'($urandom), 8'h0f));
    send_req(build_req(tftpf_pkg::REQ_PAIR, 7'($urandom), 7'($urandom), 8'($urandom),
                       8'($urandom), 4'($urandom), 8'hf0));
    send_req(build_req(tftpf_pkg::REQ_PAIR, 7'($urandom), 7'($urandom), 8'($urandom),
                       8'($urandom), 4'($urandom), 8'h5a));
    send_req(build_req(tftpf_pkg::REQ_UNUSED, 7'h7f, 7'h7f, 8'hff, 8'hff, 4'hf, 8'hff));
    send_req(build_req(tftpf_pkg::REQ_PIXEL, 7'($urandom), 7'($urandom), 8'($urandom),
                       8'($urandom), 4'h8, 8'($urandom)));

    // offsets at their maximum: start and end wrap past 255
    wait_for_bytes(SETTLE_CYCLES);
    set_offsets(8'hff, 8'hff);
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'd127, 7'd127, 8'd128, 8'd128,
                       4'($urandom), 8'($urandom)));
    send_req(build_req(tftpf_pkg::REQ_UNUSED, 7'd0, 7'd0, 8'd0, 8'd0, 4'h0, 8'h00));
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'd1, 7'd0, 8'd255, 8'd1,
                       4'($urandom), 8'($urandom)));

    // offsets at zero
    wait_for_bytes(SETTLE_CYCLES);
    set_offsets(8'd0, 8'd0);
    send_req(build_req(tftpf_pkg::REQ_WINDOW, 7'd0, 7'd0, 8'd0, 8'd0,
                       4'($urandom), 8'($urandom)));
    send_req(build_req(tftpf_pkg::REQ_PAIR, 7'($urandom), 7'($urandom), 8'($urandom),
                       8'($urandom), 4'($urandom), 8'hff));

    for (int phase = 0; phase < 4; phase++) begin
      wait_for_bytes(SETTLE_CYCLES);
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      set_offsets(pick_offset(), pick_offset());
      for (int n = 0; n < 40; n++) begin
        if (n == 20) wait_for_bytes(0);
        send_req(random_req());
      end
    end

    wait_for_bytes(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tftpf_pkg.sv
src/tftpf_front.sv
src/tftpf_queue.sv
src/tftpf_back.sv
src/tft_window_and_palette_pixel_feeder_core.sv
tb/tftpf_byte_checker.sv
tb/testbench.sv
